// File: design/bpm_pkg.sv
// ----------------------------------------------------------------------------
// Byte pattern matcher package
// Shared constants, register index codes and word types of the matcher.
// ----------------------------------------------------------------------------
package bpm_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned MaxPatternDef = 16;
  localparam int unsigned OffsetBitsDef = 32;

  // Fixed field and register widths.
  localparam int unsigned ByteW      = 8;
  localparam int unsigned PatBytes   = 16;
  localparam int unsigned PatSelW    = $clog2(PatBytes);
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned PatLenW    = 5;
  localparam int unsigned OffsetOutW = 32;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_PATTERN_LOW    = 2'd0,
    REG_PATTERN_HIGH   = 2'd1,
    REG_PATTERN_LENGTH = 2'd2
  } cfg_reg_e;

  // Input word: one byte of the searched buffer.
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             buffer_end;
  } in_word_t;

  // Output word: one reported match.
  typedef struct packed {
    logic [OffsetOutW-1:0] match_offset;
    logic                  match_in_last;
  } out_word_t;

  // Window control handed to every cell.
  typedef struct packed {
    logic shift;
    logic clear;
  } ctrl_t;

endpackage

// File: design/bpm_stream_if.sv
// ----------------------------------------------------------------------------
// Byte pattern matcher stream interface
// Valid/ready channel carrying one word of type T per handshake.
// ----------------------------------------------------------------------------
interface bpm_stream_if #(
  parameter type T = logic
);

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// File: design/bpm_cell.sv
// ----------------------------------------------------------------------------
// Byte pattern matcher window cell
// Holds one earlier byte of the buffer, passes it on to the next cell on each
// shift and compares it against the pattern byte aligned to its position.
// ----------------------------------------------------------------------------
module bpm_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bpm_pkg::ctrl_t ctrl_i,
  input  logic [7:0]    byte_i,
  input  logic          valid_i,
  input  logic [7:0]    pat_byte_i,
  input  logic          active_i,
  output logic [7:0]    byte_o,
  output logic          valid_o,
  output logic          ok_o
);

  logic [7:0] byte_q;
  logic       valid_q;

  // Valid flag: cleared at the end of a buffer, shifted in otherwise.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      valid_q <= valid_i;
    end
  end

  // Stored byte; only meaningful while the valid flag is set.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o  = byte_q;
  assign valid_o = valid_q;

  // A position beyond the pattern length never blocks a match.
  assign ok_o = !active_i || (valid_q && (byte_q == pat_byte_i));

endmodule

// File: design/bpm_out_stage.sv
// ----------------------------------------------------------------------------
// Byte pattern matcher output stage
// Output register with a one-word skid buffer behind it, so the input side
// keeps running while a found match waits to be taken.
// ----------------------------------------------------------------------------
module bpm_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  bpm_pkg::out_word_t  word_i,
  output logic                full_o,
  bpm_stream_if.source        out_o
);

  import bpm_pkg::*;

  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_word_t out_word_q, out_word_d;
  out_word_t skid_word_q, skid_word_d;
  logic      pop;

  assign pop = out_valid_q && out_o.ready;

  // Next-state logic; a push never arrives while the skid word is held.
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_word_d   = out_word_q;
    skid_word_d  = skid_word_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_word_d   = skid_word_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_word_d  = word_i;
        out_valid_d = 1'b1;
      end else begin
        skid_word_d  = word_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  // Control flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    out_word_q  <= out_word_d;
    skid_word_q <= skid_word_d;
  end

  assign full_o     = skid_valid_q;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_word_q;

endmodule

// File: design/byte_pattern_matcher.sv
// ----------------------------------------------------------------------------
// Byte pattern matcher
// Streaming search that reports the start offset of every occurrence of a
// configured pattern of 1 to MAX_PATTERN bytes, overlapping ones included.
// ----------------------------------------------------------------------------
// The matcher takes one byte per clock cycle while ready is high. Earlier
// bytes of the buffer sit in a chain of window cells that shift by one place
// for every accepted word, and all cells compare against the pattern in
// parallel, so a match is found in the cycle its last byte is accepted and is
// then registered. The output register is backed by a one-word skid
// buffer: input ready drops only when two found matches are waiting, and a
// word without a match never needs output space. A word with buffer_end set
// clears the window and restarts the offset count for the next buffer.
// Configuration registers may be written only while no match is pending.
module byte_pattern_matcher #(
  parameter int unsigned MAX_PATTERN = bpm_pkg::MaxPatternDef,
  parameter int unsigned OFFSET_BITS = bpm_pkg::OffsetBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bpm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bpm_pkg::CfgDataW-1:0] cfg_wdata_i,
  bpm_stream_if.sink                   stream_i,
  bpm_stream_if.source                 match_o
);

  import bpm_pkg::*;

  localparam int unsigned LenW = $clog2(MAX_PATTERN + 1);

  logic [CfgDataW-1:0]                pat_low_q;
  logic [CfgDataW-1:0]                pat_high_q;
  logic [PatLenW-1:0]                 pat_len_q;
  logic [PatBytes-1:0][ByteW-1:0]     pat_bytes;
  logic [LenW-1:0]                    len_eff;
  logic [MAX_PATTERN-1:0][ByteW-1:0]  win_byte;
  logic [MAX_PATTERN-1:0][ByteW-1:0]  pat_at;
  logic [MAX_PATTERN-1:0]             win_valid;
  logic [MAX_PATTERN-1:0]             active;
  logic [MAX_PATTERN-1:0]             cell_ok;
  logic [OFFSET_BITS-1:0]             offset_q;
  logic [OFFSET_BITS-1:0]             start;
  in_word_t                           in_word;
  out_word_t                          res_word;
  ctrl_t                              ctrl;
  logic                               accept;
  logic                               hit;
  logic                               skid_full;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= PatLenW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_PATTERN_LOW:    pat_low_q  <= cfg_wdata_i;
        REG_PATTERN_HIGH:   pat_high_q <= cfg_wdata_i;
        REG_PATTERN_LENGTH: pat_len_q  <= cfg_wdata_i[PatLenW-1:0];
        default: ;
      endcase
    end
  end

  assign pat_bytes = {pat_high_q, pat_low_q};

  // Pattern length in use, saturated to the window size.
  always_comb begin
    if (pat_len_q > PatLenW'(MAX_PATTERN)) begin
      len_eff = LenW'(MAX_PATTERN);
    end else begin
      len_eff = LenW'(pat_len_q);
    end
  end

  // Input handshake and window control.
  assign in_word        = stream_i.data;
  assign accept         = stream_i.valid && stream_i.ready;
  assign stream_i.ready = !skid_full;
  assign ctrl.shift     = accept && !in_word.buffer_end;
  assign ctrl.clear     = accept && in_word.buffer_end;

  // Position zero is the incoming byte itself.
  assign win_byte[0]  = in_word.data_byte;
  assign win_valid[0] = 1'b1;
  assign cell_ok[0]   = (in_word.data_byte == pat_at[0]);

  // Pattern alignment and the chain of window cells.
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_pos
    logic [PatSelW-1:0] sel;

    assign sel       = PatSelW'(32'(len_eff) - 32'(k) - 32'd1);
    assign pat_at[k] = pat_bytes[sel];
    assign active[k] = (32'(len_eff) > 32'(k));

    if (k > 0) begin : g_cell
      bpm_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctrl_i     (ctrl),
        .byte_i     (win_byte[k-1]),
        .valid_i    (win_valid[k-1]),
        .pat_byte_i (pat_at[k]),
        .active_i   (active[k]),
        .byte_o     (win_byte[k]),
        .valid_o    (win_valid[k]),
        .ok_o       (cell_ok[k])
      );
    end
  end

  // An empty pattern never matches; position zero is always in use otherwise.
  assign hit = active[0] && (&cell_ok);

  // Offset of the incoming byte within its buffer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else if (ctrl.clear) begin
      offset_q <= '0;
    end else if (ctrl.shift) begin
      offset_q <= offset_q + OFFSET_BITS'(1);
    end
  end

  // Start of the match, wrapped at the offset width.
  assign start = offset_q - OFFSET_BITS'(len_eff) + OFFSET_BITS'(1);

  assign res_word.match_offset  = OffsetOutW'(start);
  assign res_word.match_in_last = in_word.buffer_end;

  bpm_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept && hit),
    .word_i (res_word),
    .full_o (skid_full),
    .out_o  (match_o)
  );

endmodule

// File: design/bpm_checker.sv
// ----------------------------------------------------------------------------
// Byte pattern matcher checker
// Port-level assertions on the matcher, attached to the top level by bind.
// ----------------------------------------------------------------------------
module bpm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input bpm_pkg::out_word_t out_word_i
);

  // A match word stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("match word withdrawn before it was taken");

  // A stalled match word keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_word_i))
    else $error("stalled match word changed");

  // Input back-pressure only happens while matches are waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no match pending");

  // No match word appears without an accepted input byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i && !(in_valid_i && in_ready_i) |=> !out_valid_i)
    else $error("match word appeared without an accepted byte");

endmodule

bind byte_pattern_matcher bpm_checker u_bpm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (stream_i.valid),
  .in_ready_i  (stream_i.ready),
  .out_valid_i (match_o.valid),
  .out_ready_i (match_o.ready),
  .out_word_i  (match_o.data)
);
